>>> design/sgec_pkg.sv
// ----------------------------------------------------------------------------
// sgec_pkg
// Shared types and constants of the Sobel gradient edge classifier.
// ----------------------------------------------------------------------------
package sgec_pkg;

  localparam int PIXEL_W  = 8;
  localparam int GRAD_W   = 11;
  localparam int MAG_W    = 21;
  localparam int ROW_W    = 12;
  localparam int COL_W    = 11;
  localparam int IMG_WD_W = 12;
  localparam int IMG_HT_W = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam logic [IMG_WD_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [IMG_HT_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic                RST_THRESH_MODE  = 1'b1;
  localparam logic [MAG_W-1:0]    RST_SINGLE_THR   = 21'd12000;
  localparam logic [MAG_W-1:0]    RST_LOW_THR      = 21'd5000;
  localparam logic [MAG_W-1:0]    RST_HIGH_THR     = 21'd35000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_THRESH_MODE  = 3'd2,
    CFG_SINGLE_THR   = 3'd3,
    CFG_LOW_THR      = 3'd4,
    CFG_HIGH_THR     = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_WEAK   = 2'd1,
    CLS_STRONG = 2'd2
  } edge_class_e;

  localparam logic MODE_SINGLE = 1'b0;

  typedef struct packed {
    logic             ctr_valid;
    logic             ring;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } meta_t;

  typedef struct packed {
    logic             mode;
    logic [MAG_W-1:0] single_thr;
    logic [MAG_W-1:0] low_thr;
    logic [MAG_W-1:0] high_thr;
  } thresh_t;

endpackage

>>> design/sgec_line_store.sv
// ----------------------------------------------------------------------------
// sgec_line_store
// Upper and middle line memories with registered reads, one column a beat.
// ----------------------------------------------------------------------------
module sgec_line_store
  import sgec_pkg::*;
#(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  logic               clk_i,
  input  logic               rd_en_i,
  input  logic [ADDR_W-1:0]  addr_i,
  input  logic [PIXEL_W-1:0] px_i,
  input  logic               wb_en_i,
  output logic [PIXEL_W-1:0] top_o,
  output logic [PIXEL_W-1:0] mid_o
);

  logic [PIXEL_W-1:0] upr_mem [DEPTH];
  logic [PIXEL_W-1:0] mid_mem [DEPTH];
  logic [PIXEL_W-1:0] upr_rd_q;
  logic [PIXEL_W-1:0] mid_rd_q;
  logic [ADDR_W-1:0]  addr_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mid_rd_q        <= mid_mem[addr_i];
      mid_mem[addr_i] <= px_i;
    end
  end

  // middle row moves up once its beat leaves the first stage
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      upr_rd_q <= upr_mem[addr_i];
    end
    if (wb_en_i) begin
      upr_mem[addr_q] <= mid_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      addr_q <= addr_i;
    end
  end

  assign top_o = upr_rd_q;
  assign mid_o = mid_rd_q;

endmodule

>>> design/sgec_window.sv
// ----------------------------------------------------------------------------
// sgec_window
// Two stored window columns plus the incoming column; Sobel x and y kernels.
// ----------------------------------------------------------------------------
module sgec_window
  import sgec_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     shift_i,
  input  logic [PIXEL_W-1:0]       top_i,
  input  logic [PIXEL_W-1:0]       mid_i,
  input  logic [PIXEL_W-1:0]       bot_i,
  output logic signed [GRAD_W-1:0] gx_o,
  output logic signed [GRAD_W-1:0] gy_o
);

  logic [PIXEL_W-1:0] win_q [6];
  logic [PIXEL_W+1:0] left_sum;
  logic [PIXEL_W+1:0] right_sum;
  logic [PIXEL_W+1:0] upper_sum;
  logic [PIXEL_W+1:0] lower_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (shift_i) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_i;
      win_q[4] <= mid_i;
      win_q[5] <= bot_i;
    end
  end

  always_comb begin
    left_sum  = {2'b00, win_q[0]} + {1'b0, win_q[1], 1'b0} + {2'b00, win_q[2]};
    right_sum = {2'b00, top_i} + {1'b0, mid_i, 1'b0} + {2'b00, bot_i};
    upper_sum = {2'b00, win_q[0]} + {1'b0, win_q[3], 1'b0} + {2'b00, top_i};
    lower_sum = {2'b00, win_q[2]} + {1'b0, win_q[5], 1'b0} + {2'b00, bot_i};
    gx_o = $signed({1'b0, left_sum}) - $signed({1'b0, right_sum});
    gy_o = $signed({1'b0, upper_sum}) - $signed({1'b0, lower_sum});
  end

endmodule

>>> design/sgec_magnitude.sv
// ----------------------------------------------------------------------------
// sgec_magnitude
// Squared gradient magnitude, gx*gx + gy*gy.
// ----------------------------------------------------------------------------
module sgec_magnitude
  import sgec_pkg::*;
(
  input  logic signed [GRAD_W-1:0] gx_i,
  input  logic signed [GRAD_W-1:0] gy_i,
  output logic [MAG_W-1:0]         mag_o
);

  logic signed [2*GRAD_W-1:0] sq_x;
  logic signed [2*GRAD_W-1:0] sq_y;

  always_comb begin
    sq_x  = gx_i * gx_i;
    sq_y  = gy_i * gy_i;
    mag_o = sq_x[MAG_W-1:0] + sq_y[MAG_W-1:0];
  end

endmodule

>>> design/sgec_classifier.sv
// ----------------------------------------------------------------------------
// sgec_classifier
// Single or double threshold edge classification of the squared magnitude.
// ----------------------------------------------------------------------------
module sgec_classifier
  import sgec_pkg::*;
(
  input  logic [MAG_W-1:0] mag_i,
  input  logic             ring_i,
  input  thresh_t          thr_i,
  output edge_class_e      class_o
);

  always_comb begin
    if (ring_i) begin
      class_o = CLS_NONE;
    end else if (thr_i.mode == MODE_SINGLE) begin
      class_o = (mag_i > thr_i.single_thr) ? CLS_STRONG : CLS_NONE;
    end else if (mag_i < thr_i.low_thr) begin
      class_o = CLS_NONE;
    end else if (mag_i < thr_i.high_thr) begin
      class_o = CLS_WEAK;
    end else begin
      class_o = CLS_STRONG;
    end
  end

endmodule

>>> design/sobel_gradient_edge_classifier.sv
// An accepted pixel beat passes the stage 1 to 4 registers before its result is presented.
// Throughput: one pixel beat per cycle unless stalled; the pipeline rate is set by the
// single registered read port of each line memory and one multiply stage.
// Reset clears the stage valids, the window columns, the row and column
// counters and loads the register defaults; line memories are not cleared.
// ----------------------------------------------------------------------------
// sobel_gradient_edge_classifier
// Streaming 3x3 Sobel gradient, squared magnitude and edge classification.
// ----------------------------------------------------------------------------
module sobel_gradient_edge_classifier
  import sgec_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                     pix_valid_i,
  output logic                     pix_stall_o,
  input  logic [PIXEL_W-1:0]       gray_pixel_i,
  output logic                     res_valid_o,
  input  logic                     res_stall_i,
  output logic                     out_valid_o,
  output logic [ROW_W-1:0]         center_row_o,
  output logic [COL_W-1:0]         center_col_o,
  output logic signed [GRAD_W-1:0] gradient_x_o,
  output logic signed [GRAD_W-1:0] gradient_y_o,
  output logic [MAG_W-1:0]         magnitude_sq_o,
  output logic [1:0]               edge_class_o
);

  localparam int COL_CW = $clog2(MAX_WIDTH);
  localparam int ROW_CW = $clog2(MAX_HEIGHT);
  localparam int WU_W   = COL_CW + 1;
  localparam int HU_W   = ROW_CW + 1;

  // configuration
  logic [IMG_WD_W-1:0] image_width_q;
  logic [IMG_HT_W-1:0] image_height_q;
  thresh_t             thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q    <= RST_IMAGE_WIDTH;
      image_height_q   <= RST_IMAGE_HEIGHT;
      thr_q.mode       <= RST_THRESH_MODE;
      thr_q.single_thr <= RST_SINGLE_THR;
      thr_q.low_thr    <= RST_LOW_THR;
      thr_q.high_thr   <= RST_HIGH_THR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  image_width_q    <= cfg_wdata_i[IMG_WD_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_q   <= cfg_wdata_i[IMG_HT_W-1:0];
        CFG_THRESH_MODE:  thr_q.mode       <= cfg_wdata_i[0];
        CFG_SINGLE_THR:   thr_q.single_thr <= cfg_wdata_i[MAG_W-1:0];
        CFG_LOW_THR:      thr_q.low_thr    <= cfg_wdata_i[MAG_W-1:0];
        CFG_HIGH_THR:     thr_q.high_thr   <= cfg_wdata_i[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  logic [WU_W-1:0] w_use;
  logic [HU_W-1:0] h_use;

  always_comb begin
    if (image_width_q < IMG_WD_W'(3)) begin
      w_use = WU_W'(3);
    end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
      w_use = WU_W'(MAX_WIDTH);
    end else begin
      w_use = WU_W'(image_width_q);
    end
    if (image_height_q < IMG_HT_W'(3)) begin
      h_use = HU_W'(3);
    end else if (32'(image_height_q) > 32'(MAX_HEIGHT)) begin
      h_use = HU_W'(MAX_HEIGHT);
    end else begin
      h_use = HU_W'(image_height_q);
    end
  end

  // pipeline flow
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic acc, s1_fire;

  assign rdy4    = !v4_q || !res_stall_i;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign acc     = pix_valid_i && rdy1;
  assign s1_fire = v1_q && rdy2;
  assign pix_stall_o = !rdy1;
  assign res_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= pix_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // raster position
  logic [COL_CW-1:0] col_q;
  logic [ROW_CW-1:0] row_q;
  logic [WU_W-1:0]   col_inc;
  logic [HU_W-1:0]   row_inc;

  assign col_inc = {1'b0, col_q} + 1'b1;
  assign row_inc = {1'b0, row_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      if (col_inc >= w_use) begin
        col_q <= '0;
        row_q <= (row_inc >= h_use) ? '0 : row_inc[ROW_CW-1:0];
      end else begin
        col_q <= col_inc[COL_CW-1:0];
      end
    end
  end

  meta_t             meta0;
  logic [COL_CW-1:0] col_m1;
  logic [ROW_CW-1:0] row_m1;

  always_comb begin
    col_m1          = col_q - 1'b1;
    row_m1          = row_q - 1'b1;
    meta0.ctr_valid = (row_q != '0) && (col_q != '0);
    meta0.ring      = !meta0.ctr_valid || (row_q == ROW_CW'(1)) ||
                      (col_q == COL_CW'(1)) || ({1'b0, row_q} >= h_use) ||
                      ({1'b0, col_q} >= w_use);
    meta0.row       = meta0.ctr_valid ? ROW_W'(row_m1) : '0;
    meta0.col       = meta0.ctr_valid ? COL_W'(col_m1) : '0;
  end

  // stage 1: line memory read and window
  meta_t              meta1_q;
  logic [PIXEL_W-1:0] px1_q;
  logic [PIXEL_W-1:0] top_px;
  logic [PIXEL_W-1:0] mid_px;
  logic signed [GRAD_W-1:0] gx_w;
  logic signed [GRAD_W-1:0] gy_w;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      meta1_q <= meta0;
      px1_q   <= gray_pixel_i;
    end
  end

  sgec_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_CW)
  ) u_line_store (
    .clk_i   (clk_i),
    .rd_en_i (acc),
    .addr_i  (col_q),
    .px_i    (gray_pixel_i),
    .wb_en_i (s1_fire),
    .top_o   (top_px),
    .mid_o   (mid_px)
  );

  sgec_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_fire),
    .top_i   (top_px),
    .mid_i   (mid_px),
    .bot_i   (px1_q),
    .gx_o    (gx_w),
    .gy_o    (gy_w)
  );

  // stage 2: gradients
  meta_t                    meta2_q;
  logic signed [GRAD_W-1:0] gx2_q;
  logic signed [GRAD_W-1:0] gy2_q;
  logic [MAG_W-1:0]         mag_w;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      meta2_q <= meta1_q;
      gx2_q   <= meta1_q.ring ? '0 : gx_w;
      gy2_q   <= meta1_q.ring ? '0 : gy_w;
    end
  end

  sgec_magnitude u_magnitude (
    .gx_i  (gx2_q),
    .gy_i  (gy2_q),
    .mag_o (mag_w)
  );

  // stage 3: magnitude
  meta_t                    meta3_q;
  logic signed [GRAD_W-1:0] gx3_q;
  logic signed [GRAD_W-1:0] gy3_q;
  logic [MAG_W-1:0]         mag3_q;
  edge_class_e              class_w;

  always_ff @(posedge clk_i) begin
    if (v2_q && rdy3) begin
      meta3_q <= meta2_q;
      gx3_q   <= gx2_q;
      gy3_q   <= gy2_q;
      mag3_q  <= mag_w;
    end
  end

  sgec_classifier u_classifier (
    .mag_i   (mag3_q),
    .ring_i  (meta3_q.ring),
    .thr_i   (thr_q),
    .class_o (class_w)
  );

  // stage 4: result register
  always_ff @(posedge clk_i) begin
    if (v3_q && rdy4) begin
      out_valid_o    <= meta3_q.ctr_valid;
      center_row_o   <= meta3_q.row;
      center_col_o   <= meta3_q.col;
      gradient_x_o   <= gx3_q;
      gradient_y_o   <= gy3_q;
      magnitude_sq_o <= mag3_q;
      edge_class_o   <= class_w;
    end
  end

endmodule

>>> design/sgec_checker.sv
// ----------------------------------------------------------------------------
// sgec_checker
// Port-level checks of the Sobel gradient edge classifier result stream.
// ----------------------------------------------------------------------------
module sgec_checker
  import sgec_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     res_valid_o,
  input logic                     res_stall_i,
  input logic                     out_valid_o,
  input logic [ROW_W-1:0]         center_row_o,
  input logic [COL_W-1:0]         center_col_o,
  input logic signed [GRAD_W-1:0] gradient_x_o,
  input logic signed [GRAD_W-1:0] gradient_y_o,
  input logic [MAG_W-1:0]         magnitude_sq_o,
  input logic [1:0]               edge_class_o
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o)
    else $error("result beat dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> $stable(magnitude_sq_o) &&
      $stable(center_col_o) && $stable(center_row_o) && $stable(edge_class_o))
    else $error("stalled result beat changed");

  a_no_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !out_valid_o |-> center_row_o == '0 && center_col_o == '0 &&
      gradient_x_o == '0 && gradient_y_o == '0 && magnitude_sq_o == '0 &&
      edge_class_o == CLS_NONE)
    else $error("beat without center carries nonzero fields");

  a_ring_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && out_valid_o && center_col_o == '0 |-> gradient_x_o == '0 &&
      gradient_y_o == '0 && magnitude_sq_o == '0 && edge_class_o == CLS_NONE)
    else $error("first column not treated as border");

  a_ring_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && out_valid_o && center_row_o == '0 |-> gradient_x_o == '0 &&
      gradient_y_o == '0 && magnitude_sq_o == '0 && edge_class_o == CLS_NONE)
    else $error("first row not treated as border");

endmodule

bind sobel_gradient_edge_classifier sgec_checker u_sgec_checker (.*);
